@@ sv/aclpf_pkg.sv @@
// shared constants and types for the adaptive cutoff low-pass filter
`default_nettype none

package aclpf_pkg;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // fixed field widths
  localparam int OUT_W    = 32;
  localparam int EFF_W    = 17;
  localparam int EFF_BITS = 16;
  localparam int GAIN_W   = 17;
  localparam int BASE_W   = 24;
  localparam int CHG_W    = 33;
  localparam int SQ_W     = 32;
  localparam int PROD_W   = CHG_W + SQ_W;
  localparam int ACC_W    = 40;
  localparam int DIV_W    = 64;
  localparam int KT_W     = 24;
  localparam int CNT_W    = 4;
  localparam int MTDATA_W = ((OUT_W + EFF_W + 7) / 8) * 8;

  // apb side
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [EFF_W-1:0]  EFF_ONE   = 17'h1_0000;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 17'd4096;
  localparam logic [BASE_W-1:0] BASE_RST  = 24'd65536;
  localparam logic [CHG_W-1:0]  CHG_MAX   = {1'b0, {(CHG_W-1){1'b1}}};
  localparam logic [CHG_W-1:0]  CHG_MIN   = {1'b1, {(CHG_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [SQ_W:0]     SQ_LIM    = 33'h0_8000_0000;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_GAIN_ALPHA = 1'b0,
    REG_BASE_COEFF = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

@@ sv/adaptive_cutoff_low_pass_filter_unit.sv @@
// adaptive cutoff low-pass filter: sequencer around one shared multiplier and one divider
`default_nettype none

//  channel   dir   beat contents                               handshake
//  s_*       in    sample                                      s_tvalid / s_tready
//  m_*       out   filtered, efficiency                        m_tvalid / m_tready
//  apb       in    gain_alpha at 0x0, base_coeff at 0x4        psel, penable, pwrite
//
//  an item runs through two 16-step restoring divisions on one divider unit, plus
//  five passes through the shared 33x32 multiplier; the efficiency division is
//  skipped when the squared difference term is zero
//  rst clears the filter state and loads the register defaults
//  s_tready is high only while idle; a finished result sits in the output
//  register, so a stalled m_tready holds the sequencer in its last step alone

module adaptive_cutoff_low_pass_filter_unit #(
  parameter  int SAMPLE_WIDTH = aclpf_pkg::SAMPLE_WIDTH_DEF,
  parameter  int FRAC_BITS    = aclpf_pkg::FRAC_BITS_DEF,
  localparam int STDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [STDATA_W-1:0]              s_tdata,   // sample
  // result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [aclpf_pkg::MTDATA_W-1:0]   m_tdata,   // filtered, efficiency
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aclpf_pkg::PADDR_W-1:0]    paddr,
  input  logic [aclpf_pkg::PDATA_W-1:0]    pwdata,
  output logic [aclpf_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  import aclpf_pkg::*;

  localparam int SFULL_W = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DIFF_W  = ((SFULL_W > CHG_W) ? SFULL_W : CHG_W) + 1;
  localparam int CUT_SH  = FRAC_BITS - 8;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000_0000_0000_0001,
    ST_DIFF  = 15'b000_0000_0000_0010,
    ST_MULG  = 15'b000_0000_0000_0100,
    ST_CHG   = 15'b000_0000_0000_1000,
    ST_CUT   = 15'b000_0000_0001_0000,
    ST_SQC   = 15'b000_0000_0010_0000,
    ST_SQD   = 15'b000_0000_0100_0000,
    ST_SUM   = 15'b000_0000_1000_0000,
    ST_DIVE  = 15'b000_0001_0000_0000,
    ST_MULK  = 15'b000_0010_0000_0000,
    ST_KDIV  = 15'b000_0100_0000_0000,
    ST_DIVA  = 15'b000_1000_0000_0000,
    ST_MULA  = 15'b001_0000_0000_0000,
    ST_UPD   = 15'b010_0000_0000_0000,
    ST_DONE  = 15'b100_0000_0000_0000
  } state_t;

  // registers
  state_t                    state;
  logic [GAIN_W-1:0]         gain_alpha;
  logic [BASE_W-1:0]         base_coeff;
  logic signed [OUT_W-1:0]   track_value;
  logic signed [CHG_W-1:0]   change_term;
  logic signed [CHG_W-1:0]   d_val;       // saturated difference of this item
  logic [CHG_W-1:0]          opa;         // shared multiplier operands
  logic [SQ_W-1:0]           opb;
  logic [PROD_W-1:0]         prod;        // shared multiplier product
  logic                      neg;         // sign of the signed product
  logic [DIV_W-1:0]          nq;          // squared change term
  logic [DIV_W-1:0]          den;         // divider denominator
  logic [DIV_W-1:0]          rem;         // divider remainder
  logic [EFF_BITS-1:0]       quo;         // divider quotient
  logic [CNT_W-1:0]          cnt;         // divider step count
  logic [EFF_W-1:0]          eff;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_ALPHA: prdata = PDATA_W'(gain_alpha);
      REG_BASE_COEFF: prdata = PDATA_W'(base_coeff);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input difference, saturated to the change term range
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] sample_s;
  logic signed [DIFF_W-1:0]       s_wide;
  logic signed [DIFF_W-1:0]       diff_in;
  logic                           diff_ovf;
  logic [CHG_W-1:0]               d_sat;

  assign sample_s = s_tdata[SAMPLE_WIDTH-1:0];
  assign s_wide   = DIFF_W'(sample_s) <<< FRAC_BITS;
  assign diff_in  = s_wide - DIFF_W'(track_value);
  assign diff_ovf = !((&diff_in[DIFF_W-1:CHG_W-1]) || !(|diff_in[DIFF_W-1:CHG_W-1]));
  assign d_sat    = diff_ovf ? (diff_in[DIFF_W-1] ? CHG_MIN : CHG_MAX)
                             : diff_in[CHG_W-1:0];

  // d minus change, as sign and magnitude for the multiplier
  logic signed [CHG_W:0] dc;
  logic signed [CHG_W:0] dc_neg;
  logic signed [CHG_W-1:0] d_neg;

  assign dc     = {d_val[CHG_W-1], d_val} - {change_term[CHG_W-1], change_term};
  assign dc_neg = -dc;
  assign d_neg  = -d_val;

  // ---------------------------------------------------------------------------
  // signed product, floor shift and saturating accumulate
  // ---------------------------------------------------------------------------
  logic signed [PROD_W:0]  sp;
  logic signed [PROD_W:0]  sp_sh;
  logic signed [ACC_W-1:0] upd_in;
  logic signed [ACC_W-1:0] chg_sum;
  logic signed [ACC_W-1:0] trk_sum;
  logic [CHG_W-1:0]        chg_sat;
  logic [OUT_W-1:0]        trk_sat;

  assign sp      = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign sp_sh   = sp >>> EFF_BITS;
  assign upd_in  = sp_sh[ACC_W-1:0];
  assign chg_sum = upd_in + ACC_W'(change_term);
  assign trk_sum = upd_in + ACC_W'(track_value);

  always_comb begin
    if ((&chg_sum[ACC_W-1:CHG_W-1]) || !(|chg_sum[ACC_W-1:CHG_W-1])) begin
      chg_sat = chg_sum[CHG_W-1:0];
    end else begin
      chg_sat = chg_sum[ACC_W-1] ? CHG_MIN : CHG_MAX;
    end
    if ((&trk_sum[ACC_W-1:OUT_W-1]) || !(|trk_sum[ACC_W-1:OUT_W-1])) begin
      trk_sat = trk_sum[OUT_W-1:0];
    end else begin
      trk_sat = trk_sum[ACC_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  // magnitude cut to 8 fraction bits, clamped for the square
  function automatic logic [SQ_W-1:0] cut_mag(input logic signed [CHG_W-1:0] v);
    logic signed [CHG_W-1:0] c;
    logic [CHG_W-1:0]        m;
    c = v >>> CUT_SH;
    m = c[CHG_W-1] ? (~c + CHG_W'(1)) : c;
    return (m > SQ_LIM) ? SQ_LIM[SQ_W-1:0] : m[SQ_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // shared restoring divider step, one quotient bit a cycle
  // ---------------------------------------------------------------------------
  logic [DIV_W:0]        r2;
  logic [DIV_W:0]        r2_sub;
  logic                  div_ge;
  logic [DIV_W-1:0]      rem_step;
  logic [EFF_BITS-1:0]   q_step;
  logic                  div_last;

  assign r2       = {rem, 1'b0};
  assign r2_sub   = r2 - {1'b0, den};
  assign div_ge   = r2 >= {1'b0, den};
  assign rem_step = div_ge ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];
  assign q_step   = {quo[EFF_BITS-2:0], div_ge};
  assign div_last = (cnt == CNT_W'(EFF_BITS - 1));

  // efficiency shortcuts when the squared difference is zero
  logic [DIV_W-1:0] dsq;
  logic [EFF_W-1:0] eff_short;
  logic [KT_W-1:0]  kt;

  assign dsq       = prod[DIV_W-1:0];
  assign eff_short = (nq == '0) ? '0 : EFF_ONE;
  assign kt        = prod[KT_W+EFF_BITS-1:EFF_BITS];

  // ---------------------------------------------------------------------------
  // sequencer and datapath
  // ---------------------------------------------------------------------------
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      gain_alpha  <= GAIN_RST;
      base_coeff  <= BASE_RST;
      track_value <= '0;
      change_term <= '0;
      cnt         <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_GAIN_ALPHA: gain_alpha <= pwdata[GAIN_W-1:0];
          REG_BASE_COEFF: base_coeff <= pwdata[BASE_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            d_val <= d_sat;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          neg   <= dc[CHG_W];
          opa   <= dc[CHG_W] ? dc_neg[CHG_W-1:0] : dc[CHG_W-1:0];
          opb   <= SQ_W'(gain_alpha);
          state <= ST_MULG;
        end
        ST_MULG: begin
          prod  <= PROD_W'(opa) * PROD_W'(opb);
          state <= ST_CHG;
        end
        ST_CHG: begin
          change_term <= chg_sat;
          state       <= ST_CUT;
        end
        ST_CUT: begin
          opa   <= CHG_W'(cut_mag(change_term));
          opb   <= cut_mag(change_term);
          state <= ST_SQC;
        end
        ST_SQC: begin
          // square of the change term, then load the difference
          prod  <= PROD_W'(opa) * PROD_W'(opb);
          opa   <= CHG_W'(cut_mag(d_val));
          opb   <= cut_mag(d_val);
          state <= ST_SQD;
        end
        ST_SQD: begin
          nq    <= prod[DIV_W-1:0];
          prod  <= PROD_W'(opa) * PROD_W'(opb);
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (dsq == '0) begin
            // zero denominator gives 0, change alone gives one
            eff   <= eff_short;
            opa   <= CHG_W'(base_coeff);
            opb   <= SQ_W'(eff_short);
            state <= ST_MULK;
          end else begin
            rem   <= nq;
            den   <= dsq + nq;
            quo   <= '0;
            cnt   <= '0;
            state <= ST_DIVE;
          end
        end
        ST_DIVE: begin
          // the count wraps back to zero on the last step
          rem <= rem_step;
          quo <= q_step;
          cnt <= cnt + CNT_W'(1);
          if (div_last) begin
            eff   <= EFF_W'(q_step);
            opa   <= CHG_W'(base_coeff);
            opb   <= SQ_W'(q_step);
            state <= ST_MULK;
          end
        end
        ST_MULK: begin
          prod  <= PROD_W'(opa) * PROD_W'(opb);
          state <= ST_KDIV;
        end
        ST_KDIV: begin
          // alpha = kt / (kt + 1) in q0.16
          rem   <= DIV_W'(kt);
          den   <= DIV_W'(kt) + DIV_W'(EFF_ONE);
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIVA;
        end
        ST_DIVA: begin
          rem <= rem_step;
          quo <= q_step;
          cnt <= cnt + CNT_W'(1);
          if (div_last) begin
            neg   <= d_val[CHG_W-1];
            opa   <= d_val[CHG_W-1] ? d_neg : d_val;
            opb   <= SQ_W'(q_step);
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          prod  <= PROD_W'(opa) * PROD_W'(opb);
          state <= ST_UPD;
        end
        ST_UPD: begin
          track_value <= trk_sat;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= MTDATA_W'({eff, track_value});
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_eff_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_W+EFF_W-1:OUT_W] <= EFF_ONE))
    else $error("efficiency above one");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIVE && state != ST_DIVA) |-> (cnt == '0))
    else $error("divider count left running");

  a_track_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPD) |=> $stable(track_value))
    else $error("filtered value moved outside its update step");

  a_change_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CHG) |=> $stable(change_term))
    else $error("change term moved outside its update step");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && s_tready))
    else $error("finished item not presented");

endmodule

`default_nettype wire
